/* sv/qvr_pkg.sv */
// Shared types and widths for the quaternion vector rotator.
`default_nettype none
package qvr_pkg;
	localparam int COMP_W = 16;           // field width
	localparam int PROD_W = 32;           // 16x16 product
	localparam int SUM_W  = 34;           // sums of 16x16 products
	localparam int NORM_W = 33;           // |q|^2, unsigned
	localparam int TERM_W = 50;           // 16x34 product
	localparam int NUM_W  = 51;           // numerator, signed
	localparam int DVD_W  = 52;           // 2*|num| + n
	localparam int Q_BITS = 17;           // quotient bits, |r| < 2^17

	typedef struct packed {
		logic signed [COMP_W-1:0] vec_x;
		logic signed [COMP_W-1:0] vec_y;
		logic signed [COMP_W-1:0] vec_z;
		logic signed [COMP_W-1:0] quat_i;
		logic signed [COMP_W-1:0] quat_j;
		logic signed [COMP_W-1:0] quat_k;
		logic signed [COMP_W-1:0] quat_real;
	} req_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] rot_x;
		logic signed [COMP_W-1:0] rot_y;
		logic signed [COMP_W-1:0] rot_z;
		logic                     zero_quat;
		logic                     clipped;
	} rsp_t;

	// numerators and norm leaving the product pipeline
	typedef struct packed {
		logic                     valid;
		logic                     zero;
		logic [NORM_W-1:0]        norm;
		logic signed [NUM_W-1:0]  num_x;
		logic signed [NUM_W-1:0]  num_y;
		logic signed [NUM_W-1:0]  num_z;
	} num_t;

	// quotients leaving the divider
	typedef struct packed {
		logic              valid;
		logic              zero;
		logic [2:0]        neg;
		logic [Q_BITS-1:0] q_x;
		logic [Q_BITS-1:0] q_y;
		logic [Q_BITS-1:0] q_z;
	} quo_t;
endpackage
`default_nettype wire

/* sv/qvr_products.sv */
// Four-stage product pipeline: numerators of q*(v,0)*conj(q) and |q|^2.
`default_nettype none
module qvr_products (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          in_valid,
	input  wire qvr_pkg::req_t in_item,
	output qvr_pkg::num_t      num
);
	localparam int PW = qvr_pkg::PROD_W;
	localparam int SW = qvr_pkg::SUM_W;
	localparam int NW = qvr_pkg::NORM_W;
	localparam int TW = qvr_pkg::TERM_W;
	localparam int UW = qvr_pkg::NUM_W;

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	// stage 1: 16x16 products
	logic signed [PW-1:0] uxux_s1, uyuy_s1, uzuz_s1, ww_s1;
	logic signed [PW-1:0] uxvx_s1, uyvy_s1, uzvz_s1;
	logic signed [PW-1:0] uyvz_s1, uzvy_s1, uzvx_s1, uxvz_s1, uxvy_s1, uyvx_s1;
	qvr_pkg::req_t        it_s1, it_s2;

	// stage 2: sums
	logic [NW-1:0]        norm_s2, norm_s3, norm_s4;
	logic signed [SW-1:0] s_s2, uv_s2, cx_s2, cy_s2, cz_s2;
	logic                 zero_s2, zero_s3, zero_s4;

	// stage 3: wide products
	logic signed [TW-1:0] vxs_s3, vys_s3, vzs_s3;
	logic signed [TW-1:0] uxuv_s3, uyuv_s3, uzuv_s3;
	logic signed [TW-1:0] wcx_s3, wcy_s3, wcz_s3;

	// stage 4: numerators
	logic signed [UW-1:0] nx_s4, ny_s4, nz_s4;

	logic signed [SW-1:0] uu_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1   <= in_item;
			uxux_s1 <= in_item.quat_i * in_item.quat_i;
			uyuy_s1 <= in_item.quat_j * in_item.quat_j;
			uzuz_s1 <= in_item.quat_k * in_item.quat_k;
			ww_s1   <= in_item.quat_real * in_item.quat_real;
			uxvx_s1 <= in_item.quat_i * in_item.vec_x;
			uyvy_s1 <= in_item.quat_j * in_item.vec_y;
			uzvz_s1 <= in_item.quat_k * in_item.vec_z;
			uyvz_s1 <= in_item.quat_j * in_item.vec_z;
			uzvy_s1 <= in_item.quat_k * in_item.vec_y;
			uzvx_s1 <= in_item.quat_k * in_item.vec_x;
			uxvz_s1 <= in_item.quat_i * in_item.vec_z;
			uxvy_s1 <= in_item.quat_i * in_item.vec_y;
			uyvx_s1 <= in_item.quat_j * in_item.vec_x;
		end
	end

	assign uu_c = SW'(uxux_s1) + SW'(uyuy_s1) + SW'(uzuz_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s2   <= it_s1;
			norm_s2 <= NW'(SW'(ww_s1) + uu_c);
			zero_s2 <= (SW'(ww_s1) + uu_c) == '0;
			s_s2    <= SW'(ww_s1) - uu_c;
			uv_s2   <= SW'(uxvx_s1) + SW'(uyvy_s1) + SW'(uzvz_s1);
			cx_s2   <= SW'(uyvz_s1) - SW'(uzvy_s1);
			cy_s2   <= SW'(uzvx_s1) - SW'(uxvz_s1);
			cz_s2   <= SW'(uxvy_s1) - SW'(uyvx_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			norm_s3 <= norm_s2;
			zero_s3 <= zero_s2;
			vxs_s3  <= TW'(it_s2.vec_x) * TW'(s_s2);
			vys_s3  <= TW'(it_s2.vec_y) * TW'(s_s2);
			vzs_s3  <= TW'(it_s2.vec_z) * TW'(s_s2);
			uxuv_s3 <= TW'(it_s2.quat_i) * TW'(uv_s2);
			uyuv_s3 <= TW'(it_s2.quat_j) * TW'(uv_s2);
			uzuv_s3 <= TW'(it_s2.quat_k) * TW'(uv_s2);
			wcx_s3  <= TW'(it_s2.quat_real) * TW'(cx_s2);
			wcy_s3  <= TW'(it_s2.quat_real) * TW'(cy_s2);
			wcz_s3  <= TW'(it_s2.quat_real) * TW'(cz_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			norm_s4 <= norm_s3;
			zero_s4 <= zero_s3;
			nx_s4   <= UW'(vxs_s3) + (UW'(uxuv_s3) <<< 1) + (UW'(wcx_s3) <<< 1);
			ny_s4   <= UW'(vys_s3) + (UW'(uyuv_s3) <<< 1) + (UW'(wcy_s3) <<< 1);
			nz_s4   <= UW'(vzs_s3) + (UW'(uzuv_s3) <<< 1) + (UW'(wcz_s3) <<< 1);
		end
	end

	always_comb begin
		num.valid = valid_s4;
		num.zero  = zero_s4;
		num.norm  = norm_s4;
		num.num_x = nx_s4;
		num.num_y = ny_s4;
		num.num_z = nz_s4;
	end
endmodule
`default_nettype wire

/* sv/qvr_divider.sv */
// Restoring divider, one quotient bit per stage, three lanes, rounds to nearest.
`default_nettype none
module qvr_divider (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire qvr_pkg::num_t num,
	output qvr_pkg::quo_t      quo
);
	localparam int QB = qvr_pkg::Q_BITS;
	localparam int DW = qvr_pkg::DVD_W;
	localparam int NW = qvr_pkg::NORM_W;
	localparam int UW = qvr_pkg::NUM_W;

	// index 0 is the set-up stage, 1..QB produce one bit each
	logic          valid_s [0:QB];
	logic          zero_s  [0:QB];
	logic [2:0]    neg_s   [0:QB];
	logic [NW-1:0] norm_s  [0:QB];
	logic [DW-1:0] rem_s   [0:QB][0:2];
	logic [QB-1:0] q_s     [0:QB][0:2];

	logic signed [UW-1:0] nin [0:2];
	assign nin[0] = num.num_x;
	assign nin[1] = num.num_y;
	assign nin[2] = num.num_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= num.valid;
		end
	end

	// set-up: magnitude, then dividend 2|num| + n so that floor gives round half away
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s[0] <= num.zero;
			norm_s[0] <= num.norm;
			for (int l = 0; l < 3; l++) begin
				neg_s[0][l] <= nin[l][UW-1];
				rem_s[0][l] <= DW'({(nin[l][UW-1] ? -nin[l] : nin[l]), 1'b0})
					+ DW'(num.norm);
				q_s[0][l]   <= '0;
			end
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		localparam int B = QB - k;
		logic [DW-1:0] sub_c;
		logic [2:0]    ge_c;

		// divisor 2n aligned to quotient bit B
		assign sub_c = DW'({norm_s[k-1], 1'b0}) << B;
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				ge_c[l] = rem_s[k-1][l] >= sub_c;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				zero_s[k] <= zero_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				norm_s[k] <= norm_s[k-1];
				for (int l = 0; l < 3; l++) begin
					rem_s[k][l] <= ge_c[l] ? rem_s[k-1][l] - sub_c : rem_s[k-1][l];
					q_s[k][l]   <= {q_s[k-1][l][QB-2:0], ge_c[l]};
				end
			end
		end
	end

	always_comb begin
		quo.valid = valid_s[QB];
		quo.zero  = zero_s[QB];
		quo.neg   = neg_s[QB];
		quo.q_x   = q_s[QB][0];
		quo.q_y   = q_s[QB][1];
		quo.q_z   = q_s[QB][2];
	end
endmodule
`default_nettype wire

/* sv/quaternion_vector_rotate.sv */
// Top level of the quaternion vector rotator: pipeline control, saturation, output register.
//
// Rotates the vector of each request item by its quaternion: rsp = vec(q*(v,0)*q^-1),
// with q^-1 = conj(q)/|q|^2, so q need not be unit length.
// Request channel: req_valid / req_stall / req (vector Q8.8, quaternion Q2.14).
// Response channel: rsp_valid / rsp_stall / rsp (vector Q8.8, zero_quat, clipped).
// An item is taken on a rising edge with valid high and stall low.
// Throughput: one item per cycle while the receiver does not stall.
// Each item passes from the accepting edge to rsp_valid through 23 registers --
// four product stages, one divider set-up stage, seventeen divider stages
// (one quotient bit each) and the output register. The divider chain sets the depth.
// Rounding: to nearest, ties away from zero; then a component that does not fit
// in 16 bits saturates and clipped is raised. A zero quaternion gives a zero vector
// with zero_quat set.
// Stall: while rsp holds an item that the receiver stalls, the whole pipe
// freezes and req_stall is raised; nothing is dropped or repeated.
// Reset clears every valid bit; payload registers are not reset.
`default_nettype none
module quaternion_vector_rotate (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire qvr_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output qvr_pkg::rsp_t      rsp
);
	localparam int QB = qvr_pkg::Q_BITS;
	localparam int CW = qvr_pkg::COMP_W;
	localparam logic [QB-1:0] POS_MAX = QB'((1 << (CW - 1)) - 1);
	localparam logic [QB-1:0] NEG_MAX = QB'(1 << (CW - 1));

	logic          adv;
	qvr_pkg::num_t num;
	qvr_pkg::quo_t quo;
	qvr_pkg::rsp_t res_c;

	// pipe moves whenever the output register is free or being emptied
	assign adv       = !rsp_valid || !rsp_stall;
	assign req_stall = !adv;

	qvr_products u_products (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (req_valid),
		.in_item  (req),
		.num      (num)
	);

	qvr_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.num    (num),
		.quo    (quo)
	);

	// saturate one lane; returns {clip, value}
	function automatic logic [CW:0] sat_lane(input logic neg, input logic [QB-1:0] q);
		logic [CW:0] r;
		if (neg) begin
			if (q > NEG_MAX) r = {1'b1, NEG_MAX[CW-1:0]};
			else             r = {1'b0, CW'(-q)};
		end else begin
			if (q > POS_MAX) r = {1'b1, POS_MAX[CW-1:0]};
			else             r = {1'b0, q[CW-1:0]};
		end
		return r;
	endfunction

	logic [CW:0] lx_c, ly_c, lz_c;
	assign lx_c = sat_lane(quo.neg[0], quo.q_x);
	assign ly_c = sat_lane(quo.neg[1], quo.q_y);
	assign lz_c = sat_lane(quo.neg[2], quo.q_z);

	always_comb begin
		if (quo.zero) begin
			res_c.rot_x     = '0;
			res_c.rot_y     = '0;
			res_c.rot_z     = '0;
			res_c.zero_quat = 1'b1;
			res_c.clipped   = 1'b0;
		end else begin
			res_c.rot_x     = lx_c[CW-1:0];
			res_c.rot_y     = ly_c[CW-1:0];
			res_c.rot_z     = lz_c[CW-1:0];
			res_c.zero_quat = 1'b0;
			res_c.clipped   = lx_c[CW] | ly_c[CW] | lz_c[CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= quo.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp <= res_c;
		end
	end

`ifndef SYNTH
	// a zero quaternion never reports a clamp and always yields the zero vector
	a_zero_result : assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.zero_quat |->
			rsp.rot_x == '0 && rsp.rot_y == '0 && rsp.rot_z == '0 && !rsp.clipped)
		else $error("zero quaternion result not clean");

	// a clamp shows up as a rail value on at least one lane
	a_clip_rail : assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.clipped |->
			rsp.rot_x == 16'sh7fff || rsp.rot_x == -16'sh8000 ||
			rsp.rot_y == 16'sh7fff || rsp.rot_y == -16'sh8000 ||
			rsp.rot_z == 16'sh7fff || rsp.rot_z == -16'sh8000)
		else $error("clipped set without a saturated lane");
`endif
endmodule
`default_nettype wire

/* bench/tb_quaternion_vector_rotate.sv */
// Self-checking testbench for the quaternion vector rotator.
`timescale 1ns / 1ps
`default_nettype none
module tb_quaternion_vector_rotate;
	localparam int LATENCY = 22;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	qvr_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	qvr_pkg::rsp_t rsp;

	// expected rotations, oldest first
	qvr_pkg::rsp_t rot_pending[$];
	int n_sent = 0;
	int n_checked = 0;
	int n_mismatch = 0;
	int n_clipped = 0;
	int n_zero = 0;
	bit stall_random = 1'b1;   // receiver bursts on/off
	bit send_gaps = 1'b1;      // sender bursts on/off
	int hold_cycles = 0;       // receiver's own stall counter
	int long_hold_req = 0;     // long hold-off asked for by a test

	always #5 clk = ~clk;

	quaternion_vector_rotate i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Round num/den to nearest (ties away from zero), clamp to 16 bits.
	function automatic logic signed [15:0] round_clamp(longint num, longint den,
			inout bit clip);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		if (num < 0) begin
			if (q > 64'sd32768) begin
				clip = 1'b1;
				q = 64'sd32768;
			end
			return 16'(-q);
		end
		if (q > 64'sd32767) begin
			clip = 1'b1;
			q = 64'sd32767;
		end
		return 16'(q);
	endfunction

	// r = [v(w^2 - u.u) + 2u(u.v) + 2w(u x v)] / |q|^2, exact on integers
	function automatic qvr_pkg::rsp_t rotate_vector(qvr_pkg::req_t r);
		qvr_pkg::rsp_t o;
		longint vx, vy, vz, ux, uy, uz, w, uu, nrm, s, uv, cx, cy, cz;
		bit clip;
		vx = longint'(r.vec_x); vy = longint'(r.vec_y); vz = longint'(r.vec_z);
		ux = longint'(r.quat_i); uy = longint'(r.quat_j); uz = longint'(r.quat_k);
		w = longint'(r.quat_real);
		uu = ux * ux + uy * uy + uz * uz;
		nrm = w * w + uu;
		o = '0;
		clip = 1'b0;
		if (nrm == 0) begin
			o.zero_quat = 1'b1;
			return o;
		end
		s = w * w - uu;
		uv = ux * vx + uy * vy + uz * vz;
		cx = uy * vz - uz * vy;
		cy = uz * vx - ux * vz;
		cz = ux * vy - uy * vx;
		o.rot_x = round_clamp(vx * s + 2 * ux * uv + 2 * w * cx, nrm, clip);
		o.rot_y = round_clamp(vy * s + 2 * uy * uv + 2 * w * cy, nrm, clip);
		o.rot_z = round_clamp(vz * s + 2 * uz * uv + 2 * w * cz, nrm, clip);
		o.clipped = clip;
		return o;
	endfunction

	// Offer one item, hold it until taken; random gaps beforehand.
	task automatic send_rotation(qvr_pkg::req_t item);
		int gap;
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			gap = int'($urandom_range(1, 7));
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		// taken at this edge
		rot_pending.push_back(rotate_vector(item));
		n_sent++;
	endtask

	task automatic go_idle();
		req_valid <= 1'b0;
	endtask

	task automatic drain();
		go_idle();
		while (rot_pending.size() != 0) @(posedge clk);
	endtask

	function automatic qvr_pkg::req_t make_item(logic [15:0] vx, logic [15:0] vy,
			logic [15:0] vz, logic [15:0] qi, logic [15:0] qj, logic [15:0] qk,
			logic [15:0] qr);
		qvr_pkg::req_t r;
		r.vec_x = vx; r.vec_y = vy; r.vec_z = vz;
		r.quat_i = qi; r.quat_j = qj; r.quat_k = qk; r.quat_real = qr;
		return r;
	endfunction

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	// quaternion component in Q2.14: mostly within +/-1.0, sometimes any 16-bit value
	function automatic logic [15:0] rand_quat_comp();
		if ($urandom_range(0, 3) == 0) return 16'($urandom);
		return 16'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	// Receiver: random stall bursts, or a long counted hold-off.
	always @(posedge clk) begin
		if (long_hold_req > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles <= long_hold_req;
			long_hold_req = 0;
		end else if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (stall_random && $urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			hold_cycles <= int'($urandom_range(0, 6));
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Result checker: compare each taken item with the oldest expectation.
	always @(posedge clk) begin
		qvr_pkg::rsp_t exp_rot;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rot_pending.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result %h", rsp);
			end else begin
				exp_rot = rot_pending.pop_front();
				n_checked++;
				if (exp_rot.zero_quat) n_zero++;
				if (exp_rot.clipped) n_clipped++;
				if (rsp !== exp_rot) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch #%0d: exp %0d %0d %0d zq=%b cl=%b, %s",
							n_checked, exp_rot.rot_x, exp_rot.rot_y, exp_rot.rot_z,
							exp_rot.zero_quat, exp_rot.clipped,
							$sformatf("got %0d %0d %0d zq=%b cl=%b", rsp.rot_x,
								rsp.rot_y, rsp.rot_z, rsp.zero_quat, rsp.clipped));
				end
			end
		end
	end

	// Extremes, identity, zero quaternion, saturating corners.
	task automatic test_directed();
		send_rotation(make_item(16'h0100, 16'h0200, 16'hfd00, 16'h0000, 16'h0000,
			16'h0000, 16'h4000));
		send_rotation(make_item(16'h7fff, 16'h8000, 16'h1234, 16'h0000, 16'h0000,
			16'h0000, 16'h0000));
		send_rotation(make_item(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000));
		send_rotation(make_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000,
			16'h2d41, 16'h2d41));
		send_rotation(make_item(16'h8000, 16'h8000, 16'h8000, 16'h2d41, 16'h0000,
			16'h0000, 16'h2d41));
		send_rotation(make_item(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
			16'h4000, 16'h0000));
		send_rotation(make_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h7fff, 16'h7fff));
		send_rotation(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000));
		send_rotation(make_item(16'h0001, 16'hffff, 16'h0000, 16'h0001, 16'h0000,
			16'h0000, 16'h0000));
		send_rotation(make_item(16'h0003, 16'h0005, 16'hfff9, 16'h0000, 16'h0001,
			16'h0000, 16'h0001));
		send_rotation(make_item(16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0001,
			16'h0001, 16'h0001));
		send_rotation(make_item(16'h5555, 16'haaaa, 16'hffff, 16'h8000, 16'h0000,
			16'h0000, 16'h0001));
		send_rotation(make_item(16'h7fff, 16'h0000, 16'h8000, 16'h0000, 16'h8000,
			16'h0000, 16'h7fff));
		send_rotation(make_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'hffff, 16'hffff));
		drain();
	endtask

	task automatic test_random(int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 1))
				send_rotation(make_item(rand_comp(), rand_comp(), rand_comp(),
					rand_quat_comp(), rand_quat_comp(), rand_quat_comp(),
					rand_quat_comp()));
			else
				send_rotation(make_item(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
		end
	endtask

	// Receiver holds off long enough for the pipe to fill and stall its input.
	task automatic test_backpressure();
		stall_random = 1'b0;
		send_gaps = 1'b0;
		@(posedge clk);
		long_hold_req = 60;
		test_random(50);
		stall_random = 1'b1;
		send_gaps = 1'b1;
		drain();
	endtask

	// Full rate with no idling on either side.
	task automatic test_streaming();
		stall_random = 1'b0;
		send_gaps = 1'b0;
		test_random(300);
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(800);
		drain();          // sender pauses until every result is back
		test_backpressure();
		test_random(780);
		drain();
		test_streaming();
		repeat (LATENCY + 10) @(posedge clk);
		$display("Covered %0d rotations (%0d zero quaternions, %0d clipped) with",
			n_checked, n_zero, n_clipped);
		$display("random idling, a long receiver hold-off and a full-rate burst.");
		if (n_mismatch == 0 && rot_pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
